### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Each macro takes a label, a clock, an active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/ilff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilff_pkg;

	// Gap padding register.
	localparam int PAD_W = 22;
	localparam logic [PAD_W-1:0] PAD_LIMIT = 22'd3000000;

	// Fixed widths of the result fields.
	localparam int LANE_OUT_W = 6;
	localparam int Y_OUT_W = 7;
	localparam int EXTY_OUT_W = 6;

	// Input tuser bit positions.
	localparam int IN_USER_W = 3;
	localparam int IN_USER_CMD = 0;
	localparam int IN_USER_GT = 1;
	localparam int IN_USER_VIS = 2;

	// Output tuser bit positions.
	localparam int OUT_USER_W = 2;
	localparam int OUT_USER_DRAWN = 0;
	localparam int OUT_USER_FULL = 1;

	typedef enum logic {
		CMD_PLACE = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Start or clear request to the lane scanner.
	typedef struct packed {
		logic go;
		logic clear;
	} scan_cmd_t;

	// Scanner completion status.
	typedef struct packed {
		logic done;
		logic found;
	} scan_rsp_t;

	// Update strobes for the running extents.
	typedef struct packed {
		logic place;
		logic clear;
	} ext_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/ilff_lane_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ilff_lane_mem #(
	parameter int ADDR_W = 7,
	parameter int DATA_W = 48
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/ilff_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module ilff_scan #(
	parameter int LANES = 64,
	parameter int TIME_BITS = 48
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ilff_pkg::scan_cmd_t        cmd,
	input  wire logic                       sel_gt,
	input  wire logic [TIME_BITS-1:0]       start_time,
	input  wire logic [TIME_BITS-1:0]       end_time,
	input  wire logic [ilff_pkg::PAD_W-1:0] pad,
	output ilff_pkg::scan_rsp_t             rsp,
	output logic [$clog2(LANES)-1:0]        lane_idx,
	output logic                            rd_en,
	output logic [$clog2(LANES):0]          rd_addr,
	input  wire logic [TIME_BITS-1:0]       rd_data,
	output logic                            wr_en,
	output logic [$clog2(LANES):0]          wr_addr,
	output logic [TIME_BITS-1:0]            wr_data
);

	localparam int LANE_W = $clog2(LANES);
	localparam int SUM_W = ((TIME_BITS > ilff_pkg::PAD_W) ? TIME_BITS : ilff_pkg::PAD_W) + 1;
	localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

	logic              issue_vld_q;
	logic [LANE_W-1:0] issue_idx_q;
	logic              chk_vld_s1;
	logic [LANE_W-1:0] chk_idx_s1;
	logic              chk_inuse_s1;
	logic [2**(LANE_W+1)-1:0] in_use_q;

	logic [SUM_W-1:0] gap_sum;
	logic             lane_free;
	logic             done;

	// Last end plus padding, wide enough that it never wraps.
	assign gap_sum = SUM_W'(rd_data) + SUM_W'(pad);
	assign lane_free = chk_vld_s1 && (!chk_inuse_s1 || (gap_sum < SUM_W'(start_time)));
	assign done = chk_vld_s1 && (lane_free || (chk_idx_s1 == LAST_LANE));

	assign rsp.done = done;
	assign rsp.found = lane_free;
	assign lane_idx = chk_idx_s1;

	assign rd_en = issue_vld_q;
	assign rd_addr = {sel_gt, issue_idx_q};
	assign wr_en = lane_free;
	assign wr_addr = {sel_gt, chk_idx_s1};
	assign wr_data = end_time;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_vld_q <= 1'b0;
			issue_idx_q <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			chk_inuse_s1 <= 1'b0;
		end else if (cmd.go) begin
			issue_vld_q <= 1'b1;
			issue_idx_q <= '0;
			chk_vld_s1 <= 1'b0;
		end else if (done) begin
			issue_vld_q <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			chk_vld_s1 <= issue_vld_q;
			if (issue_vld_q) begin
				chk_idx_s1 <= issue_idx_q;
				chk_inuse_s1 <= in_use_q[rd_addr];
				issue_idx_q <= issue_idx_q + 1'b1;
				if (issue_idx_q == LAST_LANE) begin
					issue_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
		end else if (cmd.clear) begin
			in_use_q <= '0;
		end else if (lane_free) begin
			in_use_q[wr_addr] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ilff_extents.sv
`timescale 1ns / 1ps
`default_nettype none

module ilff_extents #(
	parameter int TIME_BITS = 48,
	parameter int Y_W = 7
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ilff_pkg::ext_ctl_t    ctl,
	input  wire logic [TIME_BITS-1:0]  start_time,
	input  wire logic [TIME_BITS-1:0]  end_time,
	input  wire logic signed [Y_W-1:0] y_pos,
	output logic [TIME_BITS-1:0]       min_start,
	output logic [TIME_BITS-1:0]       max_end,
	output logic signed [Y_W-1:0]      min_y,
	output logic signed [Y_W-1:0]      max_y
);

	logic [TIME_BITS-1:0]  min_start_q;
	logic [TIME_BITS-1:0]  max_end_q;
	logic signed [Y_W-1:0] min_y_q;
	logic signed [Y_W-1:0] max_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_start_q <= '1;
			max_end_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
		end else if (ctl.clear) begin
			min_start_q <= '1;
			max_end_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
		end else if (ctl.place) begin
			if (start_time < min_start_q) begin
				min_start_q <= start_time;
			end
			if (end_time > max_end_q) begin
				max_end_q <= end_time;
			end
			if (y_pos < min_y_q) begin
				min_y_q <= y_pos;
			end
			if (y_pos > max_y_q) begin
				max_y_q <= y_pos;
			end
		end
	end

	assign min_start = min_start_q;
	assign max_end = max_end_q;
	assign min_y = min_y_q;
	assign max_y = max_y_q;

endmodule

`default_nettype wire

### hw/rtl/interval_lane_first_fit.sv
// A place transaction scans the lanes in order, one lane per cycle from the lane-end memory,
// and takes the first lane that fits; when every lane is busy it reads all of them and
// reports a full table. A clear transaction needs no scan.
// The block works on one transaction at a time.
// Reset (arst_n low) empties both lane tables, resets the extents and zeroes the padding.
`timescale 1ns / 1ps
`default_nettype none

module interval_lane_first_fit #(
	parameter int LANES = 64,
	parameter int TIME_BITS = 48
) (
	input  wire logic clk,
	input  wire logic arst_n,

	// Gap padding register; values above the limit are held at the limit.
	input  wire logic                       cfg_we,
	input  wire logic [ilff_pkg::PAD_W-1:0] cfg_wdata,

	// Input stream.
	input  wire logic s_tvalid,
	output logic      s_tready,
	// tdata: start_time, end_time, zero fill to whole bytes
	input  wire logic [((2*TIME_BITS+7)/8)*8-1:0] s_tdata,
	// tuser: command, is_ground_truth, visible
	input  wire logic [ilff_pkg::IN_USER_W-1:0]   s_tuser,

	// Result stream.
	output logic m_tvalid,
	input  wire logic m_tready,
	// tdata: lane, y_position, min_start, max_end, min_y, max_y, zero fill to whole bytes
	output logic [((25+2*TIME_BITS+7)/8)*8-1:0] m_tdata,
	// tuser: drawn, full_res
	output logic [ilff_pkg::OUT_USER_W-1:0]     m_tuser
);

	localparam int LANE_W = $clog2(LANES);
	localparam int Y_W = LANE_W + 1;
	localparam int OUT_DW = ((25 + 2 * TIME_BITS + 7) / 8) * 8;

	// Controller state and the transaction held while it is worked on.
	ilff_pkg::state_t state_q, state_d;
	ilff_pkg::cmd_e   cmd_q;
	logic                 gt_q;
	logic                 vis_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] end_q;
	logic [ilff_pkg::PAD_W-1:0] pad_q;

	// Result waiting to be moved into the output register.
	logic [LANE_W-1:0]     res_lane_q;
	logic signed [Y_W-1:0] res_y_q;
	logic                  res_drawn_q;
	logic                  res_full_q;

	// Output register.
	logic                  m_valid_q;
	logic [OUT_DW-1:0]     m_data_q;
	logic [ilff_pkg::OUT_USER_W-1:0] m_user_q;

	logic s_accept;
	logic out_free;
	logic out_load;
	logic in_clear;

	ilff_pkg::scan_cmd_t scan_cmd;
	ilff_pkg::scan_rsp_t scan_rsp;
	ilff_pkg::ext_ctl_t  ext_ctl;
	logic [LANE_W-1:0]   scan_lane;

	logic                 rd_en;
	logic [LANE_W:0]      rd_addr;
	logic [TIME_BITS-1:0] rd_data;
	logic                 wr_en;
	logic [LANE_W:0]      wr_addr;
	logic [TIME_BITS-1:0] wr_data;

	logic [LANE_W:0]       y_mag;
	logic signed [Y_W-1:0] y_pos;

	logic [TIME_BITS-1:0]  ext_min_start;
	logic [TIME_BITS-1:0]  ext_max_end;
	logic signed [Y_W-1:0] ext_min_y;
	logic signed [Y_W-1:0] ext_max_y;

	// The block works on one transaction at a time; it takes a new one whenever the
	// controller is idle, even while the previous result still waits in the output register.
	assign s_tready = (state_q == ilff_pkg::ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign in_clear = s_tuser[ilff_pkg::IN_USER_CMD] == ilff_pkg::CMD_CLEAR;

	assign out_free = !m_valid_q || m_tready;
	assign out_load = (state_q == ilff_pkg::ST_DONE) && out_free;

	// Lane i sits at 0, 1, -1, 2, -2, ...: odd lanes above the axis, even lanes below.
	assign y_mag = ((LANE_W + 1)'(scan_lane) + 1'b1) >> 1;
	assign y_pos = scan_lane[0] ? $signed(y_mag) : -$signed(y_mag);

	// A clear acts on the edge that accepts it, so the cleared extents are already in
	// place when the result is formed in the done state.
	assign scan_cmd.go = s_accept && !in_clear;
	assign scan_cmd.clear = s_accept && in_clear;
	assign ext_ctl.clear = s_accept && in_clear;
	assign ext_ctl.place = (state_q == ilff_pkg::ST_SCAN) && scan_rsp.done && scan_rsp.found;

	ilff_lane_mem #(
		.ADDR_W(LANE_W + 1),
		.DATA_W(TIME_BITS)
	) u_lane_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	ilff_scan #(
		.LANES    (LANES),
		.TIME_BITS(TIME_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (scan_cmd),
		.sel_gt    (gt_q),
		.start_time(start_q),
		.end_time  (end_q),
		.pad       (pad_q),
		.rsp       (scan_rsp),
		.lane_idx  (scan_lane),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	ilff_extents #(
		.TIME_BITS(TIME_BITS),
		.Y_W      (Y_W)
	) u_extents (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ext_ctl),
		.start_time(start_q),
		.end_time  (end_q),
		.y_pos     (y_pos),
		.min_start (ext_min_start),
		.max_end   (ext_max_end),
		.min_y     (ext_min_y),
		.max_y     (ext_max_y)
	);

	// The padding is clamped once, when it is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= '0;
		end else if (cfg_we) begin
			pad_q <= (cfg_wdata > ilff_pkg::PAD_LIMIT) ? ilff_pkg::PAD_LIMIT : cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilff_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ilff_pkg::ST_IDLE: begin
				if (s_accept) begin
					state_d = in_clear ? ilff_pkg::ST_DONE : ilff_pkg::ST_SCAN;
				end
			end
			ilff_pkg::ST_SCAN: begin
				if (scan_rsp.done) begin
					state_d = ilff_pkg::ST_DONE;
				end
			end
			ilff_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = ilff_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ilff_pkg::ST_IDLE;
			end
		endcase
	end

	// Transaction fields, held for the whole scan.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q <= ilff_pkg::cmd_e'(s_tuser[ilff_pkg::IN_USER_CMD]);
			gt_q <= s_tuser[ilff_pkg::IN_USER_GT];
			vis_q <= s_tuser[ilff_pkg::IN_USER_VIS];
			start_q <= s_tdata[TIME_BITS-1:0];
			end_q <= s_tdata[2*TIME_BITS-1:TIME_BITS];
		end
	end

	// Per-transaction result. A clear and a scan that finds every lane busy both report
	// lane 0 at position 0, not drawn; only the busy case raises the full flag.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			res_lane_q <= '0;
			res_y_q <= '0;
			res_drawn_q <= 1'b0;
			res_full_q <= 1'b0;
		end else if ((state_q == ilff_pkg::ST_SCAN) && scan_rsp.done) begin
			if (scan_rsp.found) begin
				res_lane_q <= scan_lane;
				res_y_q <= y_pos;
				res_drawn_q <= vis_q && (cmd_q == ilff_pkg::CMD_PLACE);
				res_full_q <= 1'b0;
			end else begin
				res_full_q <= 1'b1;
			end
		end
	end

	// The extents are read from their registers in the done state, after the update
	// made at the end of the scan.
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= OUT_DW'({
				ilff_pkg::EXTY_OUT_W'(ext_max_y),
				ilff_pkg::EXTY_OUT_W'(ext_min_y),
				ext_max_end,
				ext_min_start,
				ilff_pkg::Y_OUT_W'(res_y_q),
				ilff_pkg::LANE_OUT_W'(res_lane_q)
			});
			m_user_q[ilff_pkg::OUT_USER_DRAWN] <= res_drawn_q;
			m_user_q[ilff_pkg::OUT_USER_FULL] <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tuser = m_user_q;

endmodule

`default_nettype wire

### hw/rtl/ilff_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ilff_checker #(
	parameter int TIME_BITS = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [((25+2*TIME_BITS+7)/8)*8-1:0] m_tdata,
	input wire logic [ilff_pkg::OUT_USER_W-1:0] m_tuser
);

	localparam int POS_W = ilff_pkg::LANE_OUT_W + ilff_pkg::Y_OUT_W;

	// A stalled result stays offered.
	`ASSERT_NEXT(a_out_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// A stalled result keeps its payload.
	`ASSERT_NEXT(a_out_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// A full result places nothing: lane and position are zero and nothing is drawn.
	`ASSERT_SAME(a_full_empty, clk, arst_n, m_tvalid && m_tuser[ilff_pkg::OUT_USER_FULL],
		(m_tdata[POS_W-1:0] == '0) && !m_tuser[ilff_pkg::OUT_USER_DRAWN])

	// One transaction at a time: taking one closes the input until it is done.
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind interval_lane_first_fit ilff_checker #(
	.TIME_BITS(TIME_BITS)
) u_ilff_checker (.*);

`default_nettype wire

### sim/lane_fit_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the padding register of the first-fit lane block, keeps
// its own lane tables and extents, and compares every result with the oldest
// outstanding prediction.
module lane_fit_checker #(
	parameter int LANES = 64,
	parameter int TIME_BITS = 48
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic                       cfg_we,
	input  wire logic [ilff_pkg::PAD_W-1:0] cfg_wdata,

	input  wire logic                                   s_tvalid,
	input  wire logic                                   s_tready,
	input  wire logic [((2*TIME_BITS+7)/8)*8-1:0]      s_tdata,
	input  wire logic [ilff_pkg::IN_USER_W-1:0]         s_tuser,

	input  wire logic                                   m_tvalid,
	input  wire logic                                   m_tready,
	input  wire logic [((25+2*TIME_BITS+7)/8)*8-1:0]   m_tdata,
	input  wire logic [ilff_pkg::OUT_USER_W-1:0]        m_tuser,

	output int errors,
	output int pending,
	output int full_hits,
	output int deepest_lane,
	output int clear_count
);

	import ilff_pkg::*;

	localparam int OUT_W = ((25 + 2*TIME_BITS + 7) / 8) * 8;
	localparam int LANE_LO = 0;
	localparam int Y_LO = LANE_LO + LANE_OUT_W;
	localparam int MIN_START_LO = Y_LO + Y_OUT_W;
	localparam int MAX_END_LO = MIN_START_LO + TIME_BITS;
	localparam int MIN_Y_LO = MAX_END_LO + TIME_BITS;
	localparam int MAX_Y_LO = MIN_Y_LO + EXTY_OUT_W;
	localparam int FILL_LO = MAX_Y_LO + EXTY_OUT_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [LANE_OUT_W-1:0] lane;
		logic [Y_OUT_W-1:0]    y;
		logic                  drawn;
		logic                  full;
		logic [TIME_BITS-1:0]  min_start;
		logic [TIME_BITS-1:0]  max_end;
		logic [EXTY_OUT_W-1:0] min_y;
		logic [EXTY_OUT_W-1:0] max_y;
	} lane_result_t;

	// Index 0 is the normal lane table, index 1 the ground-truth one.
	bit                   lane_used [2][LANES];
	logic [TIME_BITS-1:0] lane_end  [2][LANES];
	logic [TIME_BITS-1:0] ext_min_start;
	logic [TIME_BITS-1:0] ext_max_end;
	int                   ext_min_y;
	int                   ext_max_y;
	logic [PAD_W-1:0]     padding;

	lane_result_t placements_due[$];

	initial begin
		errors = 0;
		pending = 0;
		full_hits = 0;
		deepest_lane = 0;
		clear_count = 0;
	end

	function automatic void clear_lanes();
		for (int t = 0; t < 2; t++) begin
			for (int k = 0; k < LANES; k++) begin
				lane_used[t][k] = 1'b0;
				lane_end[t][k] = '0;
			end
		end
		ext_min_start = TIME_MAX;
		ext_max_end = '0;
		ext_min_y = 0;
		ext_max_y = 0;
	endfunction

	function automatic lane_result_t first_fit(cmd_e cmd, logic [TIME_BITS-1:0] st,
			logic [TIME_BITS-1:0] en, logic gt, logic vis);
		lane_result_t r;
		logic [TIME_BITS-1:0] pad;
		int gi;
		int pick;
		int yv;
		r = '0;
		pad = (padding > PAD_LIMIT) ? TIME_BITS'(PAD_LIMIT) : TIME_BITS'(padding);
		gi = gt ? 1 : 0;
		pick = -1;
		if (cmd == CMD_CLEAR) begin
			clear_lanes();
			clear_count++;
		end else begin
			// A lane whose end plus padding would run past the time range stays busy.
			for (int k = 0; k < LANES && pick < 0; k++) begin
				if (!lane_used[gi][k])
					pick = k;
				else if (lane_end[gi][k] <= TIME_MAX - pad && lane_end[gi][k] + pad < st)
					pick = k;
			end
			if (pick < 0) begin
				r.full = 1'b1;
				full_hits++;
			end else begin
				lane_used[gi][pick] = 1'b1;
				lane_end[gi][pick] = en;
				yv = (pick % 2 == 0) ? -((pick + 1) / 2) : (pick + 1) / 2;
				if (st < ext_min_start)
					ext_min_start = st;
				if (en > ext_max_end)
					ext_max_end = en;
				if (yv < ext_min_y)
					ext_min_y = yv;
				if (yv > ext_max_y)
					ext_max_y = yv;
				if (pick > deepest_lane)
					deepest_lane = pick;
				r.lane = pick[LANE_OUT_W-1:0];
				r.y = yv[Y_OUT_W-1:0];
				r.drawn = vis;
			end
		end
		r.min_start = ext_min_start;
		r.max_end = ext_max_end;
		r.min_y = ext_min_y[EXTY_OUT_W-1:0];
		r.max_y = ext_max_y[EXTY_OUT_W-1:0];
		return r;
	endfunction

	// Prints one line for the mismatch and counts it.
	task automatic report_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
		errors++;
		$display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lane_result_t want;
		lane_result_t got;
		if (!arst_n) begin
			clear_lanes();
			padding = '0;
			placements_due.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.lane = m_tdata[LANE_LO +: LANE_OUT_W];
				got.y = m_tdata[Y_LO +: Y_OUT_W];
				got.min_start = m_tdata[MIN_START_LO +: TIME_BITS];
				got.max_end = m_tdata[MAX_END_LO +: TIME_BITS];
				got.min_y = m_tdata[MIN_Y_LO +: EXTY_OUT_W];
				got.max_y = m_tdata[MAX_Y_LO +: EXTY_OUT_W];
				got.drawn = m_tuser[OUT_USER_DRAWN];
				got.full = m_tuser[OUT_USER_FULL];
				if (placements_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", '0, got.lane);
				end else begin
					want = placements_due.pop_front();
					if (got.lane !== want.lane)
						report_mismatch("lane", want.lane, got.lane);
					if (got.y !== want.y)
						report_mismatch("y_position", want.y, got.y);
					if (got.drawn !== want.drawn)
						report_mismatch("drawn", want.drawn, got.drawn);
					if (got.full !== want.full)
						report_mismatch("full_res", want.full, got.full);
					if (got.min_start !== want.min_start)
						report_mismatch("min_start", want.min_start, got.min_start);
					if (got.max_end !== want.max_end)
						report_mismatch("max_end", want.max_end, got.max_end);
					if (got.min_y !== want.min_y)
						report_mismatch("min_y", want.min_y, got.min_y);
					if (got.max_y !== want.max_y)
						report_mismatch("max_y", want.max_y, got.max_y);
					if (m_tdata[OUT_W-1:FILL_LO] !== '0)
						report_mismatch("tdata fill", '0, m_tdata[OUT_W-1:FILL_LO]);
				end
			end
			if (s_tvalid && s_tready)
				placements_due.insert(placements_due.size(),
					first_fit(cmd_e'(s_tuser[IN_USER_CMD]),
					s_tdata[0 +: TIME_BITS], s_tdata[TIME_BITS +: TIME_BITS],
					s_tuser[IN_USER_GT], s_tuser[IN_USER_VIS]));
			if (cfg_we)
				padding = cfg_wdata;
			pending = placements_due.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import ilff_pkg::*;

	localparam int LANES = 64;
	localparam int TIME_BITS = 48;
	localparam int IN_W = ((2*TIME_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((25 + 2*TIME_BITS + 7) / 8) * 8;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam int ITEMS_PER_PHASE = 120;
	// Long enough for a slow but correct run many times over.
	localparam int WATCHDOG_CYCLES = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             cfg_we = 1'b0;
	logic [PAD_W-1:0] cfg_wdata = '0;

	logic                 s_tvalid = 1'b0;
	wire logic            s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;

	wire logic                  m_tvalid;
	logic                       m_tready = 1'b0;
	wire logic [OUT_W-1:0]      m_tdata;
	wire logic [OUT_USER_W-1:0] m_tuser;

	int errors;
	int pending;
	int full_hits;
	int deepest_lane;
	int clear_count;

	// Chance in percent that the sender idles before a transaction, and that the
	// receiver holds off in a given cycle.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Cycles left in a long receiver hold-off; counted down by the receiver process.
	int hold_left = 0;
	int items_sent = 0;
	logic [PAD_W-1:0] cur_padding = '0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	interval_lane_first_fit #(
		.LANES(LANES),
		.TIME_BITS(TIME_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	lane_fit_checker #(
		.LANES(LANES),
		.TIME_BITS(TIME_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.errors(errors),
		.pending(pending),
		.full_hits(full_hits),
		.deepest_lane(deepest_lane),
		.clear_count(clear_count)
	);

	// Receiver side. During a long hold-off the block keeps one result waiting and
	// so has to drop s_tready while the sender keeps offering.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		repeat (WATCHDOG_CYCLES) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding", WATCHDOG_CYCLES,
			pending);
		$display("Verification failed");
		$finish;
	end

	function automatic logic [TIME_BITS-1:0] rand_time();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[TIME_BITS-1:0];
	endfunction

	// Adds without wrapping, so that a run of sorted starts stays sorted near the top.
	function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a,
			longint unsigned b);
		if (b > TIME_MAX - a)
			return TIME_MAX;
		return a + TIME_BITS'(b);
	endfunction

	// Offers one transaction and returns at the falling edge after it was taken.
	// Must be called just after a falling edge.
	task automatic push_item(cmd_e cmd, logic [TIME_BITS-1:0] st, logic [TIME_BITS-1:0] en,
			logic gt, logic vis);
		logic [IN_USER_W-1:0] u;
		u = '0;
		u[IN_USER_CMD] = cmd;
		u[IN_USER_GT] = gt;
		u[IN_USER_VIS] = vis;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {en, st};
		s_tuser <= u;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Waits until every outstanding result has come back, then lets the block settle.
	task automatic wait_drained();
		int waited;
		waited = 0;
		while (pending != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (LANES + 8) @(negedge clk);
	endtask

	// The padding register is only written while the block is idle.
	task automatic write_padding(logic [PAD_W-1:0] value);
		s_tvalid <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cur_padding = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One layout run: a clear, then intervals with rising starts and random content.
	// Dense runs keep nearly all intervals overlapping in one table so that every lane
	// fills and the block reports a full table. A tenth of the transactions are noise
	// with arbitrary times, and some ends lie before their starts.
	task automatic run_frame(bit dense);
		logic [TIME_BITS-1:0] t;
		logic [TIME_BITS-1:0] st;
		logic [TIME_BITS-1:0] en;
		int n;
		int roll;
		int eff_pad;
		bit gt_main;
		bit gt;
		eff_pad = (cur_padding > PAD_LIMIT) ? int'(PAD_LIMIT) : int'(cur_padding);
		push_item(CMD_CLEAR, rand_time(), rand_time(), $urandom_range(1), $urandom_range(1));
		case ($urandom_range(7))
			0, 1: t = '0;
			2, 3, 4: t = TIME_BITS'($urandom_range(100000));
			5, 6: t = rand_time();
			default: t = TIME_MAX - TIME_BITS'($urandom_range(50000000));
		endcase
		n = dense ? $urandom_range(90, 140) : $urandom_range(25, 60);
		gt_main = $urandom_range(1);
		for (int i = 0; i < n; i++) begin
			gt = ($urandom_range(9) == 0) ? !gt_main : gt_main;
			roll = $urandom_range(99);
			if (!dense && roll < 2) begin
				push_item(CMD_CLEAR, rand_time(), rand_time(), gt, $urandom_range(1));
			end else begin
				if (roll < 10) begin
					st = rand_time();
					en = rand_time();
				end else begin
					t = sat_add(t, dense ? $urandom_range(3) : $urandom_range(eff_pad / 16 + 500));
					st = t;
					if (roll < 15)
						en = st - TIME_BITS'($urandom_range(1000));
					else if (dense)
						en = sat_add(st, 64'd1000000 + $urandom);
					else
						en = sat_add(st, $urandom_range(eff_pad / 4 + 3000));
				end
				push_item(CMD_PLACE, st, en, gt, $urandom_range(3) != 0);
			end
		end
	endtask

	initial begin
		int phase_start;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the reset padding of zero. A lane whose end equals the new
		// start is still busy; ground-truth and normal tables are independent.
		push_item(CMD_PLACE, '0, '0, 1'b0, 1'b1);
		push_item(CMD_PLACE, '0, 48'd5, 1'b0, 1'b1);
		push_item(CMD_PLACE, 48'd1, 48'd10, 1'b0, 1'b0);
		push_item(CMD_PLACE, '0, TIME_MAX, 1'b1, 1'b1);
		push_item(CMD_PLACE, TIME_MAX, TIME_MAX, 1'b1, 1'b1);
		push_item(CMD_PLACE, 48'd20, 48'd3, 1'b0, 1'b1);
		push_item(CMD_PLACE, TIME_MAX, '0, 1'b0, 1'b1);
		push_item(CMD_CLEAR, TIME_MAX, TIME_MAX, 1'b1, 1'b1);
		push_item(CMD_PLACE, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b1);
		push_item(CMD_PLACE, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b1, 1'b0);

		// A padding above the limit acts as the limit. Near the top of the time range
		// the end plus padding would overflow, so that lane counts as busy.
		write_padding('1);
		push_item(CMD_CLEAR, '0, '0, 1'b0, 1'b0);
		push_item(CMD_PLACE, 48'd100, 48'd200, 1'b0, 1'b1);
		push_item(CMD_PLACE, 48'd3000200, 48'd3000300, 1'b0, 1'b1);
		push_item(CMD_PLACE, 48'd3000201, 48'd3000400, 1'b0, 1'b1);
		push_item(CMD_PLACE, TIME_MAX - 48'd2000000, TIME_MAX - 48'd1000, 1'b1, 1'b1);
		push_item(CMD_PLACE, TIME_MAX, TIME_MAX, 1'b1, 1'b0);
		push_item(CMD_PLACE, TIME_MAX, 48'd7, 1'b0, 1'b1);

		// Random part in four handshake phases, each with its own padding setting:
		// no random idling, a slow sender, a slow receiver, then both slightly idle.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_padding('0);
				1: write_padding(PAD_LIMIT);
				2: write_padding(PAD_LIMIT + 22'd1);
				default: write_padding(PAD_W'($urandom_range(20000)));
			endcase
			send_idle_pct = (ph == 1) ? 77 : (ph == 3) ? 13 : 0;
			recv_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 13 : 0;
			// Long receiver hold-off while the sender keeps going at full rate.
			if (ph == 0)
				hold_left = 400;
			phase_start = items_sent;
			run_frame(1'b1);
			while (items_sent - phase_start < ITEMS_PER_PHASE)
				run_frame($urandom_range(9) < 3);
		end

		s_tvalid <= 1'b0;
		wait_drained();

		$display("Sent %0d transactions, %0d of them clears; %0d placements found a full table.",
			items_sent, clear_count, full_hits);
		$display("Deepest lane used was %0d; padding ran from zero to past its limit.",
			deepest_lane);
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ilff_pkg.sv
hw/rtl/ilff_lane_mem.sv
hw/rtl/ilff_scan.sv
hw/rtl/ilff_extents.sv
hw/rtl/interval_lane_first_fit.sv
hw/rtl/ilff_checker.sv
sim/lane_fit_checker.sv
sim/testbench.sv
